[rtl/scsa_pkg.sv]
// Shared types, constants and address helper for the size-class slot allocator.
// Used by scsa_bitmap_mem, scsa_ctrl and size_class_slot_allocator_top.
package scsa_pkg;

  localparam int SLOTS_PER_ARRAY = 768;
  localparam int MAX_POOLS       = 8;
  localparam int MAX_ARRAYS      = 16;

  localparam int BITS_PER_WORD   = 64;
  localparam int WORDS_PER_ARRAY = (SLOTS_PER_ARRAY + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int TOTAL_WORDS     = MAX_POOLS * MAX_ARRAYS * WORDS_PER_ARRAY;
  localparam int ADDR_W          = $clog2(TOTAL_WORDS);
  localparam int LAST_WORD_BITS  = SLOTS_PER_ARRAY - (WORDS_PER_ARRAY - 1) * BITS_PER_WORD;

  localparam int KEY_W    = 16;
  localparam int POOL_W   = 3;
  localparam int ARR_W    = 4;
  localparam int SLOT_W   = 10;
  localparam int BIT_W    = 6;
  localparam int WIDX_W   = SLOT_W - BIT_W;
  localparam int PCNT_W   = 4;
  localparam int ACNT_W   = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_POOL     = 2'd1,
    ST_NO_ARRAY    = 2'd2,
    ST_BAD_RELEASE = 2'd3
  } status_t;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACQ_LOOK,
    S_ACQ_RD,
    S_ACQ_CHK,
    S_ACQ_OPEN,
    S_ACQ_SWEEP,
    S_REL_CHK,
    S_REL_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [POOL_W-1:0] pool;
    logic [ARR_W-1:0]  arr;
    logic [SLOT_W-1:0] slot;
  } result_t;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [BITS_PER_WORD-1:0] wr_data;
  } mem_req_t;

  // Word address of one bitmap word: (pool * MAX_ARRAYS + arr) * WORDS_PER_ARRAY + word.
  function automatic logic [ADDR_W-1:0] word_addr(input logic [POOL_W-1:0] pool,
                                                  input logic [ARR_W-1:0]  arr,
                                                  input logic [WIDX_W-1:0] word);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'({pool, arr});
    return ADDR_W'(row * ADDR_W'(WORDS_PER_ARRAY)) + ADDR_W'(word);
  endfunction

endpackage

[rtl/scsa_bitmap_mem.sv]
// Busy bitmap store: one synchronous RAM of 64-bit words, one write and one read port.
// Depends on scsa_pkg for widths and the request struct.
module scsa_bitmap_mem (
  input  logic                                clk,
  input  scsa_pkg::mem_req_t                  req,
  output logic [scsa_pkg::BITS_PER_WORD-1:0]  rd_data
);

  logic [scsa_pkg::BITS_PER_WORD-1:0] mem [scsa_pkg::TOTAL_WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/scsa_ctrl.sv]
// Sequencer for acquire and release: pool lookup, bitmap scan, array open and release.
// Depends on scsa_pkg; drives the bitmap RAM through a request struct.
module scsa_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_take,
  input  logic                                in_opcode,
  input  logic [scsa_pkg::KEY_W-1:0]          in_capacity_key,
  input  logic [scsa_pkg::POOL_W-1:0]         in_release_pool,
  input  logic [scsa_pkg::ARR_W-1:0]          in_release_array,
  input  logic [scsa_pkg::SLOT_W-1:0]         in_release_slot,
  input  logic                                res_room,
  input  logic [scsa_pkg::BITS_PER_WORD-1:0]  rd_data,
  output scsa_pkg::mem_req_t                  mem_req,
  output logic                                busy,
  output logic                                res_valid,
  output scsa_pkg::result_t                   res
);

  localparam logic [scsa_pkg::WIDX_W-1:0] LAST_WORD =
    scsa_pkg::WIDX_W'(scsa_pkg::WORDS_PER_ARRAY - 1);

  scsa_pkg::state_t state_r, state_nxt;

  logic [scsa_pkg::KEY_W-1:0]  key_r,   key_nxt;
  logic [scsa_pkg::POOL_W-1:0] rpool_r, rpool_nxt;
  logic [scsa_pkg::ARR_W-1:0]  rarr_r,  rarr_nxt;
  logic [scsa_pkg::SLOT_W-1:0] rslot_r, rslot_nxt;
  logic [scsa_pkg::POOL_W-1:0] pool_r,  pool_nxt;
  logic [scsa_pkg::ARR_W-1:0]  arr_r,   arr_nxt;
  logic [scsa_pkg::WIDX_W-1:0] word_r,  word_nxt;
  scsa_pkg::result_t           res_r,   res_nxt;

  logic [scsa_pkg::PCNT_W-1:0] pools_used_r, pools_used_nxt;
  logic [scsa_pkg::ACNT_W-1:0] arrays_used_r [scsa_pkg::MAX_POOLS];
  logic [scsa_pkg::KEY_W-1:0]  pool_key_r    [scsa_pkg::MAX_POOLS];

  logic                        key_wr, arr_clr, arr_inc;
  logic [scsa_pkg::POOL_W-1:0] new_pool;

  // Key match over the open pools, lowest index wins.
  logic                        hit;
  logic [scsa_pkg::POOL_W-1:0] hit_idx;
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = scsa_pkg::MAX_POOLS - 1; i >= 0; i--) begin
      if ((scsa_pkg::PCNT_W'(i) < pools_used_r) && (pool_key_r[i] == key_r)) begin
        hit     = 1'b1;
        hit_idx = scsa_pkg::POOL_W'(i);
      end
    end
  end

  // Bits past the end of the array count as busy in the last word.
  logic [scsa_pkg::BITS_PER_WORD-1:0] eff_word;
  logic                               has_free;
  logic [scsa_pkg::BIT_W-1:0]         free_bit;
  always_comb begin
    eff_word = rd_data;
    if (word_r == LAST_WORD) begin
      for (int b = scsa_pkg::LAST_WORD_BITS; b < scsa_pkg::BITS_PER_WORD; b++) begin
        eff_word[b] = 1'b1;
      end
    end
    has_free = ~&eff_word;
    free_bit = '0;
    for (int b = scsa_pkg::BITS_PER_WORD - 1; b >= 0; b--) begin
      if (!eff_word[b]) begin
        free_bit = scsa_pkg::BIT_W'(b);
      end
    end
  end

  logic [scsa_pkg::ACNT_W-1:0] cur_arrays;
  logic [scsa_pkg::ACNT_W-1:0] next_arr;
  logic                        rel_bad;
  assign cur_arrays = arrays_used_r[pool_r];
  assign next_arr   = {1'b0, arr_r} + scsa_pkg::ACNT_W'(1);
  assign rel_bad    = ({1'b0, rpool_r} >= pools_used_r) ||
                      ({1'b0, rarr_r} >= arrays_used_r[rpool_r]) ||
                      (rslot_r >= scsa_pkg::SLOT_W'(scsa_pkg::SLOTS_PER_ARRAY));

  // Next state and outputs.
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    rpool_nxt      = rpool_r;
    rarr_nxt       = rarr_r;
    rslot_nxt      = rslot_r;
    pool_nxt       = pool_r;
    arr_nxt        = arr_r;
    word_nxt       = word_r;
    res_nxt        = res_r;
    pools_used_nxt = pools_used_r;
    key_wr         = 1'b0;
    arr_clr        = 1'b0;
    arr_inc        = 1'b0;
    new_pool       = pools_used_r[scsa_pkg::POOL_W-1:0];
    mem_req        = '0;
    res_valid      = 1'b0;

    unique case (state_r)
      scsa_pkg::S_IDLE: begin
        if (in_take) begin
          key_nxt   = in_capacity_key;
          rpool_nxt = in_release_pool;
          rarr_nxt  = in_release_array;
          rslot_nxt = in_release_slot;
          state_nxt = (in_opcode == scsa_pkg::OP_RELEASE) ? scsa_pkg::S_REL_CHK
                                                          : scsa_pkg::S_ACQ_LOOK;
        end
      end

      scsa_pkg::S_ACQ_LOOK: begin
        arr_nxt  = '0;
        word_nxt = '0;
        if (hit) begin
          pool_nxt  = hit_idx;
          state_nxt = (arrays_used_r[hit_idx] != '0) ? scsa_pkg::S_ACQ_RD
                                                     : scsa_pkg::S_ACQ_OPEN;
        end else if (pools_used_r == scsa_pkg::PCNT_W'(scsa_pkg::MAX_POOLS)) begin
          res_nxt   = '{status: scsa_pkg::ST_NO_POOL, default: '0};
          state_nxt = scsa_pkg::S_FIN;
        end else begin
          // Open the next pool and record its key.
          key_wr         = 1'b1;
          arr_clr        = 1'b1;
          pool_nxt       = new_pool;
          pools_used_nxt = pools_used_r + scsa_pkg::PCNT_W'(1);
          state_nxt      = scsa_pkg::S_ACQ_OPEN;
        end
      end

      scsa_pkg::S_ACQ_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = scsa_pkg::word_addr(pool_r, arr_r, word_r);
        state_nxt       = scsa_pkg::S_ACQ_CHK;
      end

      scsa_pkg::S_ACQ_CHK: begin
        if (has_free) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = scsa_pkg::word_addr(pool_r, arr_r, word_r);
          mem_req.wr_data = rd_data |
                            (scsa_pkg::BITS_PER_WORD'(1) << free_bit);
          res_nxt         = '{status: scsa_pkg::ST_OK, pool: pool_r, arr: arr_r,
                              slot: {word_r, free_bit}};
          state_nxt       = scsa_pkg::S_FIN;
        end else if (word_r != LAST_WORD) begin
          word_nxt  = word_r + scsa_pkg::WIDX_W'(1);
          state_nxt = scsa_pkg::S_ACQ_RD;
        end else if (next_arr == cur_arrays) begin
          state_nxt = scsa_pkg::S_ACQ_OPEN;
        end else begin
          arr_nxt   = arr_r + scsa_pkg::ARR_W'(1);
          word_nxt  = '0;
          state_nxt = scsa_pkg::S_ACQ_RD;
        end
      end

      scsa_pkg::S_ACQ_OPEN: begin
        if (cur_arrays == scsa_pkg::ACNT_W'(scsa_pkg::MAX_ARRAYS)) begin
          res_nxt   = '{status: scsa_pkg::ST_NO_ARRAY, default: '0};
          state_nxt = scsa_pkg::S_FIN;
        end else begin
          arr_inc   = 1'b1;
          arr_nxt   = cur_arrays[scsa_pkg::ARR_W-1:0];
          word_nxt  = '0;
          state_nxt = scsa_pkg::S_ACQ_SWEEP;
        end
      end

      // Clear the new array word by word; word 0 gets slot 0 taken.
      scsa_pkg::S_ACQ_SWEEP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = scsa_pkg::word_addr(pool_r, arr_r, word_r);
        mem_req.wr_data = (word_r == '0) ? scsa_pkg::BITS_PER_WORD'(1) : '0;
        if (word_r == LAST_WORD) begin
          res_nxt   = '{status: scsa_pkg::ST_OK, pool: pool_r, arr: arr_r, slot: '0};
          state_nxt = scsa_pkg::S_FIN;
        end else begin
          word_nxt = word_r + scsa_pkg::WIDX_W'(1);
        end
      end

      scsa_pkg::S_REL_CHK: begin
        if (rel_bad) begin
          res_nxt   = '{status: scsa_pkg::ST_BAD_RELEASE, default: '0};
          state_nxt = scsa_pkg::S_FIN;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = scsa_pkg::word_addr(rpool_r, rarr_r,
                                                rslot_r[scsa_pkg::SLOT_W-1:scsa_pkg::BIT_W]);
          state_nxt       = scsa_pkg::S_REL_WR;
        end
      end

      scsa_pkg::S_REL_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = scsa_pkg::word_addr(rpool_r, rarr_r,
                                              rslot_r[scsa_pkg::SLOT_W-1:scsa_pkg::BIT_W]);
        mem_req.wr_data = rd_data &
                          ~(scsa_pkg::BITS_PER_WORD'(1) << rslot_r[scsa_pkg::BIT_W-1:0]);
        res_nxt         = '{status: scsa_pkg::ST_OK, default: '0};
        state_nxt       = scsa_pkg::S_FIN;
      end

      scsa_pkg::S_FIN: begin
        if (res_room) begin
          res_valid = 1'b1;
          state_nxt = scsa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = scsa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != scsa_pkg::S_IDLE);
  assign res  = res_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scsa_pkg::S_IDLE;
      pools_used_r <= '0;
      for (int i = 0; i < scsa_pkg::MAX_POOLS; i++) begin
        arrays_used_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      pools_used_r <= pools_used_nxt;
      if (arr_clr) begin
        arrays_used_r[new_pool] <= '0;
      end else if (arr_inc) begin
        arrays_used_r[pool_r] <= cur_arrays + scsa_pkg::ACNT_W'(1);
      end
    end
  end

  // Working registers and pool keys.
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    rpool_r <= rpool_nxt;
    rarr_r  <= rarr_nxt;
    rslot_r <= rslot_nxt;
    pool_r  <= pool_nxt;
    arr_r   <= arr_nxt;
    word_r  <= word_nxt;
    res_r   <= res_nxt;
    if (key_wr) begin
      pool_key_r[new_pool] <= key_r;
    end
  end

endmodule

[rtl/size_class_slot_allocator_top.sv]
// Size-class slot allocator: one acquire or release at a time, one result beat each.
// Release checks the request, reads the bitmap word and writes it back with the slot cleared;
// a bad release skips the read and write. Acquire looks up the pool, then reads and checks
// one bitmap word at a time; opening an array claims it and then sweeps over its words. A
// new beat is taken once the previous result sits in the output register. Synchronous reset
// empties all pools; arrays are swept when opened, so the bitmap RAM needs no clearing pass.
// Depends on scsa_pkg, scsa_bitmap_mem and scsa_ctrl.
module size_class_slot_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [scsa_pkg::KEY_W-1:0]  in_capacity_key,
  input  logic [scsa_pkg::POOL_W-1:0] in_release_pool,
  input  logic [scsa_pkg::ARR_W-1:0]  in_release_array,
  input  logic [scsa_pkg::SLOT_W-1:0] in_release_slot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scsa_pkg::STATUS_W-1:0] out_status,
  output logic [scsa_pkg::POOL_W-1:0] out_granted_pool,
  output logic [scsa_pkg::ARR_W-1:0]  out_granted_array,
  output logic [scsa_pkg::SLOT_W-1:0] out_granted_slot
);

  scsa_pkg::mem_req_t                 mem_req;
  logic [scsa_pkg::BITS_PER_WORD-1:0] rd_data;
  logic                               busy;
  logic                               res_valid;
  scsa_pkg::result_t                  res;
  logic                               out_valid_r;
  scsa_pkg::result_t                  out_res_r;
  logic                               res_room;

  assign in_stall = busy;
  assign res_room = !out_valid_r || !out_stall;

  scsa_bitmap_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  scsa_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_take          (in_valid && !busy),
    .in_opcode        (in_opcode),
    .in_capacity_key  (in_capacity_key),
    .in_release_pool  (in_release_pool),
    .in_release_array (in_release_array),
    .in_release_slot  (in_release_slot),
    .res_room         (res_room),
    .rd_data          (rd_data),
    .mem_req          (mem_req),
    .busy             (busy),
    .res_valid        (res_valid),
    .res              (res)
  );

  // Output register holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_granted_pool  = out_res_r.pool;
  assign out_granted_array = out_res_r.arr;
  assign out_granted_slot  = out_res_r.slot;

endmodule

[verif/tb_size_class_slot_allocator_top.sv]
// Self-checking testbench for size_class_slot_allocator_top: directed table, random
// acquire/release traffic with idling and back-pressure.
// Depends on scsa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_size_class_slot_allocator_top;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 8000000;
  localparam int DRAIN_CYCLES = 500;

  typedef struct {
    scsa_pkg::opcode_t           op;
    logic [scsa_pkg::KEY_W-1:0]  key;
    logic [scsa_pkg::POOL_W-1:0] pool;
    logic [scsa_pkg::ARR_W-1:0]  arr;
    logic [scsa_pkg::SLOT_W-1:0] slot;
    bit                          known;
    scsa_pkg::status_t           status;
    logic [scsa_pkg::POOL_W-1:0] gpool;
    logic [scsa_pkg::ARR_W-1:0]  garr;
    logic [scsa_pkg::SLOT_W-1:0] gslot;
  } req_row_t;

  typedef struct {
    scsa_pkg::status_t           status;
    logic [scsa_pkg::POOL_W-1:0] pool;
    logic [scsa_pkg::ARR_W-1:0]  arr;
    logic [scsa_pkg::SLOT_W-1:0] slot;
  } grant_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  logic [scsa_pkg::KEY_W-1:0] in_capacity_key;
  logic [scsa_pkg::POOL_W-1:0] in_release_pool;
  logic [scsa_pkg::ARR_W-1:0] in_release_array;
  logic [scsa_pkg::SLOT_W-1:0] in_release_slot;
  logic out_valid;
  logic out_stall;
  logic [scsa_pkg::STATUS_W-1:0] out_status;
  logic [scsa_pkg::POOL_W-1:0] out_granted_pool;
  logic [scsa_pkg::ARR_W-1:0] out_granted_array;
  logic [scsa_pkg::SLOT_W-1:0] out_granted_slot;

  size_class_slot_allocator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_capacity_key(in_capacity_key),
    .in_release_pool(in_release_pool),
    .in_release_array(in_release_array),
    .in_release_slot(in_release_slot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_granted_pool(out_granted_pool),
    .out_granted_array(out_granted_array),
    .out_granted_slot(out_granted_slot)
  );

  // Shadow copy of the allocator state.
  bit [scsa_pkg::SLOTS_PER_ARRAY-1:0] slot_busy [scsa_pkg::MAX_POOLS][scsa_pkg::MAX_ARRAYS];
  logic [scsa_pkg::KEY_W-1:0] pool_key [scsa_pkg::MAX_POOLS];
  int open_pools;
  int open_arrays [scsa_pkg::MAX_POOLS];

  grant_t pending_grants[$];
  grant_t held_slots[$];
  req_row_t dir_tbl[$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  bit start_hold;
  int mismatches;
  longint cycles;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("size_class_slot_allocator_top: mismatch");
      $finish;
    end
  end

  // Works out the grant for one request and updates the shadow state.
  function automatic grant_t allocate_or_free(scsa_pkg::opcode_t op,
                                              logic [scsa_pkg::KEY_W-1:0] key,
                                              int p, int a, int s);
    grant_t g;
    int pi;
    bit found;
    g = '{scsa_pkg::ST_OK, '0, '0, '0};
    if (op == scsa_pkg::OP_RELEASE) begin
      if (p >= open_pools || a >= open_arrays[p] || s >= scsa_pkg::SLOTS_PER_ARRAY)
        g.status = scsa_pkg::ST_BAD_RELEASE;
      else
        slot_busy[p][a][s] = 1'b0;
      return g;
    end
    found = 0;
    pi = 0;
    for (int i = 0; i < open_pools; i++) begin
      if (!found && pool_key[i] == key) begin
        found = 1;
        pi = i;
      end
    end
    if (!found) begin
      if (open_pools >= scsa_pkg::MAX_POOLS) begin
        g.status = scsa_pkg::ST_NO_POOL;
        return g;
      end
      pi = open_pools;
      pool_key[pi] = key;
      open_arrays[pi] = 0;
      open_pools++;
    end
    // Lowest clear bit across the open arrays of this pool.
    for (int ai = 0; ai < open_arrays[pi]; ai++) begin
      if (~slot_busy[pi][ai] != '0) begin
        for (int si = 0; si < scsa_pkg::SLOTS_PER_ARRAY; si++) begin
          if (!slot_busy[pi][ai][si]) begin
            slot_busy[pi][ai][si] = 1'b1;
            g.pool = scsa_pkg::POOL_W'(pi);
            g.arr = scsa_pkg::ARR_W'(ai);
            g.slot = scsa_pkg::SLOT_W'(si);
            return g;
          end
        end
      end
    end
    if (open_arrays[pi] >= scsa_pkg::MAX_ARRAYS) begin
      g.status = scsa_pkg::ST_NO_ARRAY;
      return g;
    end
    slot_busy[pi][open_arrays[pi]] = '0;
    slot_busy[pi][open_arrays[pi]][0] = 1'b1;
    g.pool = scsa_pkg::POOL_W'(pi);
    g.arr = scsa_pkg::ARR_W'(open_arrays[pi]);
    open_arrays[pi]++;
    return g;
  endfunction

  // Offers one beat, waits for its acceptance and records the expected grant.
  task automatic offer(req_row_t r);
    grant_t g;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= r.op;
    in_capacity_key <= r.key;
    in_release_pool <= r.pool;
    in_release_array <= r.arr;
    in_release_slot <= r.slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = allocate_or_free(r.op, r.key, r.pool, r.arr, r.slot);
    if (r.known) begin
      g = '{r.status, r.gpool, r.garr, r.gslot};
    end
    if (r.op == scsa_pkg::OP_ACQUIRE && g.status == scsa_pkg::ST_OK) held_slots.push_back(g);
    pending_grants.push_back(g);
  endtask

  function automatic req_row_t acq(logic [scsa_pkg::KEY_W-1:0] key);
    return '{scsa_pkg::OP_ACQUIRE, key, scsa_pkg::POOL_W'($urandom),
             scsa_pkg::ARR_W'($urandom), scsa_pkg::SLOT_W'($urandom), 1'b0,
             scsa_pkg::ST_OK, '0, '0, '0};
  endfunction

  function automatic req_row_t rel(int p, int a, int s);
    return '{scsa_pkg::OP_RELEASE, scsa_pkg::KEY_W'($urandom), scsa_pkg::POOL_W'(p),
             scsa_pkg::ARR_W'(a), scsa_pkg::SLOT_W'(s), 1'b0, scsa_pkg::ST_OK,
             '0, '0, '0};
  endfunction

  // Receiver stall pattern, with a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    hold_off = 0;
    wait (start_hold);
    @(posedge clk);
    hold_off = 1;
    repeat (600) @(posedge clk);
    hold_off = 0;
  end

  // Result checker.
  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result beat with nothing expected at cycle %0d", cycles);
      end else begin
        e = pending_grants.pop_front();
        if (out_status !== e.status || out_granted_pool !== e.pool ||
            out_granted_array !== e.arr || out_granted_slot !== e.slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Grant mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     e.status, e.pool, e.arr, e.slot, out_status, out_granted_pool,
                     out_granted_array, out_granted_slot);
        end
      end
    end
  end

  initial begin
    req_row_t r;
    int pick;
    int key_set [10];
    mismatches = 0;
    start_hold = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    open_pools = 0;
    for (int p = 0; p < scsa_pkg::MAX_POOLS; p++) begin
      open_arrays[p] = 0;
      pool_key[p] = '0;
      for (int a = 0; a < scsa_pkg::MAX_ARRAYS; a++) slot_busy[p][a] = '0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = scsa_pkg::OP_ACQUIRE;
    in_capacity_key = '0;
    in_release_pool = '0;
    in_release_array = '0;
    in_release_slot = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, both operations, errors and free-slot release.
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h0000, 0, 0, 0, 1, scsa_pkg::ST_OK, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h0000, 0, 0, 0, 1, scsa_pkg::ST_OK, 0, 0, 1});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'hFFFF, 0, 0, 0, 1, scsa_pkg::ST_OK, 1, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'h0000, 0, 0, 0, 1, scsa_pkg::ST_OK, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h0000, 0, 0, 0, 1, scsa_pkg::ST_OK, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'hFFFF, 0, 0, 767, 1, scsa_pkg::ST_OK,
                        0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'h0000, 0, 0, 768, 1,
                        scsa_pkg::ST_BAD_RELEASE, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'h0000, 0, 0, 1023, 1,
                        scsa_pkg::ST_BAD_RELEASE, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'h0000, 0, 1, 0, 1,
                        scsa_pkg::ST_BAD_RELEASE, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'h0000, 7, 0, 0, 1,
                        scsa_pkg::ST_BAD_RELEASE, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'h0000, 1, 0, 0, 1, scsa_pkg::ST_OK, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'h0000, 1, 0, 0, 1, scsa_pkg::ST_OK, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h5555, 0, 0, 0, 1, scsa_pkg::ST_OK, 2, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'hAAAA, 0, 0, 0, 1, scsa_pkg::ST_OK, 3, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h0001, 0, 0, 0, 1, scsa_pkg::ST_OK, 4, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h8000, 0, 0, 0, 1, scsa_pkg::ST_OK, 5, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h00FF, 0, 0, 0, 1, scsa_pkg::ST_OK, 6, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'hFF00, 0, 0, 0, 1, scsa_pkg::ST_OK, 7, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h1234, 0, 0, 0, 1,
                        scsa_pkg::ST_NO_POOL, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_RELEASE, 16'hFFFF, 7, 15, 1023, 1,
                        scsa_pkg::ST_BAD_RELEASE, 0, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'hFFFF, 0, 0, 0, 1, scsa_pkg::ST_OK, 1, 0, 0});
    dir_tbl.push_back('{scsa_pkg::OP_ACQUIRE, 16'h0000, 0, 0, 0, 0, scsa_pkg::ST_OK, 0, 0, 0});
    foreach (dir_tbl[i]) offer(dir_tbl[i]);

    // Random traffic in three idling phases; mostly valid acquire/release pairs.
    key_set = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001,
                16'h8000, 16'h00FF, 16'hFF00, 16'h1234, 16'h4321};
    for (int n = 0; n < 700; n++) begin
      if (n == 0) begin
        send_idle_pct = 35;
        recv_idle_pct = 76;
      end else if (n == 233) begin
        send_idle_pct = 76;
        recv_idle_pct = 35;
      end else if (n == 466) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 40) start_hold = 1;
      pick = $urandom_range(99);
      if (pick < 50) begin
        r = acq((pick < 5) ? 16'($urandom) : 16'(key_set[$urandom_range(9)]));
      end else if (pick < 85 && held_slots.size() > 0) begin
        pick = $urandom_range(held_slots.size() - 1);
        r = rel(held_slots[pick].pool, held_slots[pick].arr, held_slots[pick].slot);
        held_slots.delete(pick);
      end else begin
        r = rel($urandom_range(7), $urandom_range(15), $urandom_range(1023));
      end
      offer(r);
    end
    in_valid <= 1'b0;

    while (pending_grants.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("size_class_slot_allocator_top: match");
    else
      $display("size_class_slot_allocator_top: mismatch");
    $finish;
  end

endmodule
